>>> rtl/gee_pkg.sv
// ----------------------------------------------------------------------------
// gee_pkg
// Shared types and constants of the Gaussian elimination engine: operation
// codes, controller and FPU states, and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package gee_pkg;

    localparam int IDX_W  = 6;
    localparam int CNT_W  = IDX_W + 1;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DATA_W = 32;
    localparam int NCFG_W = 7;
    localparam int DIM    = 1 << IDX_W;

    localparam logic [NCFG_W-1:0] N_RESET = NCFG_W'(DIM);
    localparam logic [DATA_W-1:0] FP_ONE  = 32'h3F80_0000;
    localparam logic [DATA_W-1:0] FP_ZERO = 32'h0000_0000;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_START = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic {
        FOP_DIV,
        FOP_MSUB
    } fop_t;

    typedef enum logic [1:0] {
        WSEL_ITEM,
        WSEL_FPU,
        WSEL_ONE,
        WSEL_ZERO
    } wsel_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MEM_WR,
        S_MEM_RD,
        S_RESP,
        S_E_INIT,
        S_PIV_RD,
        S_PIV_LD,
        S_SC_CHK,
        S_SC_RD,
        S_SC_GO,
        S_SC_WAIT,
        S_DIAG_WR,
        S_ROW_CHK,
        S_FAC_RD,
        S_FAC_LD,
        S_EL_CHK,
        S_B_RD,
        S_B_LD,
        S_EL_GO,
        S_EL_WAIT,
        S_ZERO_WR,
        S_K_NEXT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        F_IDLE,
        F_MUL,
        F_SUBSPEC,
        F_ALIGN,
        F_ADD,
        F_DIVSPEC,
        F_DIVIT,
        F_LZC,
        F_SHIFT,
        F_ROUND
    } fpu_state_t;

    typedef struct packed {
        logic              ld_item;
        logic              mem_rd;
        logic              mem_we;
        logic              addr_item;
        logic [ADDR_W-1:0] addr;
        wsel_t             wsel;
        logic              ld_piv;
        logic              ld_fac;
        logic              ld_opb;
        logic              fpu_start;
        fop_t              fpu_op;
        logic              out_load;
        logic              out_read;
    } dp_cmd_t;

    typedef struct packed {
        logic fpu_done;
    } dp_stat_t;

endpackage

>>> rtl/gee_fpu.sv
// ----------------------------------------------------------------------------
// gee_fpu
// Multi-cycle single-precision unit: x / d, and a - f*b with the product
// rounded before the subtraction. Round to nearest even, subnormals kept.
// ----------------------------------------------------------------------------
module gee_fpu
    import gee_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  fop_t              op,
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    input  logic [DATA_W-1:0] c,
    output logic              done,
    output logic [DATA_W-1:0] result
);

    localparam int M_W = 50;
    localparam int E_W = 12;
    localparam int L_W = 6;

    localparam logic [DATA_W-1:0] QNAN_DEF = 32'hFFC0_0000;
    localparam logic [DATA_W-1:0] QNAN_POS = 32'h7FC0_0000;
    localparam logic [DATA_W-1:0] QUIET    = 32'h0040_0000;
    localparam logic [30:0]       INF_MAG  = 31'h7F80_0000;

    typedef struct packed {
        logic        sign;
        logic [7:0]  exp;
        logic [23:0] mant;
        logic        nan;
        logic        inf;
        logic        zero;
    } unp_t;

    function automatic unp_t unpack(input logic [DATA_W-1:0] x);
        unp_t u;
        u.sign = x[31];
        u.exp  = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        u.mant = {x[30:23] != 8'd0, x[22:0]};
        u.nan  = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
        u.inf  = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
        u.zero = (x[30:0] == 31'd0);
        return u;
    endfunction

    function automatic logic [L_W-1:0] lzc50(input logic [M_W-1:0] x);
        logic [L_W-1:0] n;
        n = L_W'(M_W);
        for (int i = 0; i < M_W; i++) begin
            if (x[i]) begin
                n = L_W'(M_W - 1 - i);
            end
        end
        return n;
    endfunction

    function automatic logic [4:0] lzc24(input logic [23:0] x);
        logic [4:0] n;
        n = 5'd24;
        for (int i = 0; i < 24; i++) begin
            if (x[i]) begin
                n = 5'(23 - i);
            end
        end
        return n;
    endfunction

    fpu_state_t state_reg, state_next;

    logic [DATA_W-1:0]    a_reg, b_reg, c_reg, p_reg, result_reg;
    logic                 done_reg;
    logic                 mul_phase_reg;
    logic                 nrm_sign_reg, nrm_zsign_reg;
    logic signed [E_W-1:0] nrm_exp_reg;
    logic [M_W-1:0]       nrm_m_reg;
    logic [L_W-1:0]       lz_reg;
    logic [M_W-1:0]       sh_m_reg;
    logic signed [E_W-1:0] sh_exp_reg;
    logic                 sh_zero_reg;
    logic [23:0]          al_big_reg, al_small_reg;
    logic [7:0]           al_exp_reg, al_diff_reg;
    logic                 al_sign_reg, al_sub_reg;
    logic [M_W-1:0]       al_sh_reg;
    logic [25:0]          rem_reg;
    logic [23:0]          dvs_reg;
    logic [M_W-1:0]       q_reg;
    logic [L_W-1:0]       cnt_reg;

    unp_t u_a, u_b, u_c, u_p;
    logic [47:0]          prod;
    logic                 spec_hit;
    logic [DATA_W-1:0]    spec_val;
    logic                 a_big;
    logic [M_W-1:0]       small_ext, small_sh, small_lost;
    logic [M_W-1:0]       big_ext, add_m;
    logic [4:0]           lzx, lzd;
    logic [23:0]          mxn, mdn;
    logic signed [E_W-1:0] div_exp;
    logic                 div_ge;
    logic [25:0]          div_rem;
    logic signed [E_W-1:0] e_lz, rs;
    logic [M_W-1:0]       sh_m;
    logic signed [E_W-1:0] sh_e;
    logic [23:0]          rnd_m;
    logic                 rnd_inc;
    logic [24:0]          rnd_sum;
    logic signed [E_W-1:0] rnd_e;
    logic [DATA_W-1:0]    rnd_val;

    assign done   = done_reg;
    assign result = result_reg;

    always_comb begin
        u_a  = unpack(a_reg);
        u_b  = unpack(b_reg);
        u_c  = unpack(c_reg);
        u_p  = unpack(p_reg);
        prod = u_b.mant * u_c.mant;

        spec_hit = 1'b0;
        spec_val = FP_ZERO;
        case (state_reg)
            F_MUL: begin
                spec_hit = u_b.nan || u_c.nan || u_b.inf || u_c.inf;
                if (u_b.nan) begin
                    spec_val = b_reg | QUIET;
                end else if (u_c.nan) begin
                    spec_val = c_reg | QUIET;
                end else if ((u_b.inf && u_c.zero) || (u_b.zero && u_c.inf)) begin
                    spec_val = QNAN_DEF;
                end else begin
                    spec_val = {u_b.sign ^ u_c.sign, INF_MAG};
                end
            end
            F_SUBSPEC: begin
                spec_hit = u_a.nan || u_p.nan || u_a.inf || u_p.inf;
                if (u_a.nan) begin
                    spec_val = a_reg | QUIET;
                end else if (u_p.nan) begin
                    spec_val = p_reg | QUIET;
                end else if (u_a.inf && u_p.inf) begin
                    spec_val = (u_a.sign == u_p.sign) ? QNAN_DEF : a_reg;
                end else if (u_a.inf) begin
                    spec_val = a_reg;
                end else begin
                    spec_val = {~p_reg[31], p_reg[30:0]};
                end
            end
            F_DIVSPEC: begin
                spec_hit = u_b.zero || u_a.nan || u_b.nan || u_a.inf || u_b.inf || u_a.zero;
                if (u_b.zero) begin
                    if (u_a.nan) begin
                        spec_val = a_reg;
                    end else if (u_a.zero) begin
                        spec_val = QNAN_POS;
                    end else begin
                        spec_val = {u_a.sign ^ u_b.sign, INF_MAG};
                    end
                end else if (u_a.nan) begin
                    spec_val = a_reg | QUIET;
                end else if (u_b.nan) begin
                    spec_val = b_reg | QUIET;
                end else if (u_a.inf && u_b.inf) begin
                    spec_val = QNAN_DEF;
                end else if (u_a.inf) begin
                    spec_val = {u_a.sign ^ u_b.sign, INF_MAG};
                end else begin
                    spec_val = {u_a.sign ^ u_b.sign, 31'd0};
                end
            end
            default: begin
                spec_hit = 1'b0;
            end
        endcase

        a_big = {u_a.exp, u_a.mant} >= {u_p.exp, u_p.mant};

        small_ext  = {1'b0, al_small_reg, 25'd0};
        small_lost = small_ext << (8'd50 - al_diff_reg);
        if (al_diff_reg >= 8'd50) begin
            small_sh = {{(M_W-1){1'b0}}, |al_small_reg};
        end else begin
            small_sh = (small_ext >> al_diff_reg) | {{(M_W-1){1'b0}}, |small_lost};
        end
        big_ext = {1'b0, al_big_reg, 25'd0};
        add_m   = al_sub_reg ? (big_ext - al_sh_reg) : (big_ext + al_sh_reg);

        lzx     = lzc24(u_a.mant);
        lzd     = lzc24(u_b.mant);
        mxn     = u_a.mant << lzx;
        mdn     = u_b.mant << lzd;
        div_exp = E_W'(u_a.exp) - E_W'(lzx) - E_W'(u_b.exp) + E_W'(lzd) + E_W'(127);
        div_ge  = rem_reg >= {2'b0, dvs_reg};
        div_rem = div_ge ? (rem_reg - {2'b0, dvs_reg}) : rem_reg;

        e_lz = nrm_exp_reg - $signed(E_W'(lz_reg));
        rs   = E_W'(1) - nrm_exp_reg;
        if (e_lz >= 1) begin
            sh_m = nrm_m_reg << lz_reg;
            sh_e = e_lz;
        end else if (nrm_exp_reg >= 1) begin
            sh_m = nrm_m_reg << L_W'(nrm_exp_reg - E_W'(1));
            sh_e = E_W'(1);
        end else if (rs >= E_W'(M_W)) begin
            sh_m = {{(M_W-1){1'b0}}, |nrm_m_reg};
            sh_e = E_W'(1);
        end else begin
            sh_m = (nrm_m_reg >> L_W'(rs))
                 | {{(M_W-1){1'b0}}, (nrm_m_reg << L_W'(E_W'(M_W) - rs)) != '0};
            sh_e = E_W'(1);
        end

        rnd_inc = sh_m_reg[25] & ((|sh_m_reg[24:0]) | sh_m_reg[26]);
        rnd_sum = {1'b0, sh_m_reg[49:26]} + 25'(rnd_inc);
        if (rnd_sum[24]) begin
            rnd_m = rnd_sum[24:1];
            rnd_e = sh_exp_reg + E_W'(1);
        end else begin
            rnd_m = rnd_sum[23:0];
            rnd_e = sh_exp_reg;
        end
        if (sh_zero_reg) begin
            rnd_val = {nrm_zsign_reg, 31'd0};
        end else if (rnd_e >= E_W'(255)) begin
            rnd_val = {nrm_sign_reg, INF_MAG};
        end else begin
            rnd_val = {nrm_sign_reg, rnd_m[23] ? rnd_e[7:0] : 8'd0, rnd_m[22:0]};
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (start) begin
                    state_next = (op == FOP_DIV) ? F_DIVSPEC : F_MUL;
                end
            end
            F_MUL:     state_next = spec_hit ? F_SUBSPEC : F_LZC;
            F_SUBSPEC: state_next = spec_hit ? F_IDLE : F_ALIGN;
            F_ALIGN:   state_next = F_ADD;
            F_ADD:     state_next = F_LZC;
            F_DIVSPEC: state_next = spec_hit ? F_IDLE : F_DIVIT;
            F_DIVIT: begin
                if (cnt_reg == L_W'(M_W - 1)) begin
                    state_next = F_LZC;
                end
            end
            F_LZC:     state_next = F_SHIFT;
            F_SHIFT:   state_next = F_ROUND;
            F_ROUND:   state_next = mul_phase_reg ? F_SUBSPEC : F_IDLE;
            default:   state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= ((state_reg == F_SUBSPEC || state_reg == F_DIVSPEC) && spec_hit)
                      || (state_reg == F_ROUND && !mul_phase_reg);
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            F_IDLE: begin
                if (start) begin
                    a_reg <= a;
                    b_reg <= b;
                    c_reg <= c;
                end
            end
            F_MUL: begin
                if (spec_hit) begin
                    p_reg <= spec_val;
                end else begin
                    nrm_m_reg     <= {prod, 2'b00};
                    nrm_exp_reg   <= E_W'(u_b.exp) + E_W'(u_c.exp) - E_W'(126);
                    nrm_sign_reg  <= u_b.sign ^ u_c.sign;
                    nrm_zsign_reg <= u_b.sign ^ u_c.sign;
                    mul_phase_reg <= 1'b1;
                end
            end
            F_SUBSPEC: begin
                if (spec_hit) begin
                    result_reg <= spec_val;
                end else begin
                    al_big_reg    <= a_big ? u_a.mant : u_p.mant;
                    al_small_reg  <= a_big ? u_p.mant : u_a.mant;
                    al_exp_reg    <= a_big ? u_a.exp : u_p.exp;
                    al_diff_reg   <= a_big ? (u_a.exp - u_p.exp) : (u_p.exp - u_a.exp);
                    al_sign_reg   <= a_big ? u_a.sign : ~u_p.sign;
                    al_sub_reg    <= (u_a.sign == u_p.sign);
                    nrm_zsign_reg <= (u_a.sign != u_p.sign) & u_a.sign;
                end
            end
            F_ALIGN: begin
                al_sh_reg <= small_sh;
            end
            F_ADD: begin
                nrm_m_reg     <= add_m;
                nrm_exp_reg   <= E_W'(al_exp_reg) + E_W'(1);
                nrm_sign_reg  <= al_sign_reg;
                mul_phase_reg <= 1'b0;
            end
            F_DIVSPEC: begin
                if (spec_hit) begin
                    result_reg <= spec_val;
                end else begin
                    rem_reg       <= {2'b00, mxn};
                    dvs_reg       <= mdn;
                    q_reg         <= '0;
                    cnt_reg       <= '0;
                    nrm_exp_reg   <= div_exp;
                    nrm_sign_reg  <= u_a.sign ^ u_b.sign;
                    nrm_zsign_reg <= u_a.sign ^ u_b.sign;
                    mul_phase_reg <= 1'b0;
                end
            end
            F_DIVIT: begin
                rem_reg <= {div_rem[24:0], 1'b0};
                q_reg   <= {q_reg[M_W-2:0], div_ge};
                cnt_reg <= cnt_reg + L_W'(1);
                if (cnt_reg == L_W'(M_W - 1)) begin
                    nrm_m_reg <= {q_reg[M_W-2:0], div_ge | (div_rem != 26'd0)};
                end
            end
            F_LZC: begin
                lz_reg <= lzc50(nrm_m_reg);
            end
            F_SHIFT: begin
                sh_m_reg    <= sh_m;
                sh_exp_reg  <= sh_e;
                sh_zero_reg <= (nrm_m_reg == '0);
            end
            F_ROUND: begin
                if (mul_phase_reg) begin
                    p_reg <= rnd_val;
                end else begin
                    result_reg <= rnd_val;
                end
            end
            default: begin
                result_reg <= result_reg;
            end
        endcase
    end

endmodule

>>> rtl/gee_datapath.sv
// ----------------------------------------------------------------------------
// gee_datapath
// Matrix store, operand registers, the floating-point unit and the result
// register, all steered by the controller's command.
// ----------------------------------------------------------------------------
module gee_datapath
    import gee_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat,
    input  logic [IDX_W-1:0]  s_row,
    input  logic [IDX_W-1:0]  s_col,
    input  logic [DATA_W-1:0] s_value,
    output logic [DATA_W-1:0] m_read_value,
    output logic              m_done_res
);

    logic [DATA_W-1:0] mem [DIM*DIM];

    logic [IDX_W-1:0]  row_reg, col_reg;
    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic [DATA_W-1:0] piv_reg, fac_reg, opb_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic              out_done_reg;

    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] fpu_b;
    logic [DATA_W-1:0] fpu_result;
    logic              fpu_done;

    assign addr  = cmd.addr_item ? {row_reg, col_reg} : cmd.addr;
    assign fpu_b = (cmd.fpu_op == FOP_DIV) ? piv_reg : fac_reg;

    always_comb begin
        case (cmd.wsel)
            WSEL_ITEM: wdata = val_reg;
            WSEL_FPU:  wdata = fpu_result;
            WSEL_ONE:  wdata = FP_ONE;
            WSEL_ZERO: wdata = FP_ZERO;
            default:   wdata = FP_ZERO;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_we) begin
            mem[addr] <= wdata;
        end
        if (cmd.mem_rd) begin
            rdata_reg <= mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_item) begin
            row_reg <= s_row;
            col_reg <= s_col;
            val_reg <= s_value;
        end
        if (cmd.ld_piv) begin
            piv_reg <= rdata_reg;
        end
        if (cmd.ld_fac) begin
            fac_reg <= rdata_reg;
        end
        if (cmd.ld_opb) begin
            opb_reg <= rdata_reg;
        end
        if (cmd.out_load) begin
            out_value_reg <= cmd.out_read ? rdata_reg : FP_ZERO;
            out_done_reg  <= 1'b1;
        end
    end

    gee_fpu u_fpu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.fpu_start),
        .op      (cmd.fpu_op),
        .a       (rdata_reg),
        .b       (fpu_b),
        .c       (opb_reg),
        .done    (fpu_done),
        .result  (fpu_result)
    );

    assign stat.fpu_done = fpu_done;
    assign m_read_value  = out_value_reg;
    assign m_done_res    = out_done_reg;

endmodule

>>> rtl/gee_ctrl.sv
// ----------------------------------------------------------------------------
// gee_ctrl
// Item handshake, size register and the pivot/row/column sequencer that
// walks the elimination and issues datapath commands.
// ----------------------------------------------------------------------------
module gee_ctrl
    import gee_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_operation,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [NCFG_W-1:0] cfg_data,
    output logic              m_valid,
    input  logic              m_ready,
    output dp_cmd_t           cmd,
    input  dp_stat_t          stat
);

    ctrl_state_t       state_reg, state_next;
    op_t               op_reg, op_next;
    logic [NCFG_W-1:0] n_reg;
    logic [CNT_W-1:0]  neff_reg, neff_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic              out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]  n_sat;

    function automatic logic [ADDR_W-1:0] mk_addr(input logic [CNT_W-1:0] r,
                                                  input logic [CNT_W-1:0] cc);
        return {r[IDX_W-1:0], cc[IDX_W-1:0]};
    endfunction

    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign n_sat     = (n_reg > NCFG_W'(DIM)) ? CNT_W'(DIM) : CNT_W'(n_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            n_reg         <= N_RESET;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                n_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        neff_reg <= neff_next;
        k_reg    <= k_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
    end

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        neff_next      = neff_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        out_valid_next = out_valid_reg & ~m_ready;
        s_ready        = 1'b0;
        cmd            = '0;
        cmd.wsel       = WSEL_ITEM;
        cmd.fpu_op     = FOP_DIV;

        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next     = op_t'(s_operation);
                    cmd.ld_item = 1'b1;
                    case (op_t'(s_operation))
                        OP_WRITE: state_next = S_MEM_WR;
                        OP_READ:  state_next = S_MEM_RD;
                        OP_START: state_next = S_E_INIT;
                        default:  state_next = S_RESP;
                    endcase
                end
            end
            S_MEM_WR: begin
                cmd.mem_we    = 1'b1;
                cmd.addr_item = 1'b1;
                cmd.wsel      = WSEL_ITEM;
                state_next    = S_RESP;
            end
            S_MEM_RD: begin
                cmd.mem_rd    = 1'b1;
                cmd.addr_item = 1'b1;
                state_next    = S_RESP;
            end
            S_RESP: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_read   = (op_reg == OP_READ);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_E_INIT: begin
                neff_next  = n_sat;
                k_next     = '0;
                state_next = (n_sat == '0) ? S_RESP : S_PIV_RD;
            end
            S_PIV_RD: begin
                cmd.mem_rd = 1'b1;
                cmd.addr   = mk_addr(k_reg, k_reg);
                state_next = S_PIV_LD;
            end
            S_PIV_LD: begin
                cmd.ld_piv = 1'b1;
                j_next     = k_reg + CNT_W'(1);
                state_next = S_SC_CHK;
            end
            S_SC_CHK: begin
                state_next = (j_reg < neff_reg) ? S_SC_RD : S_DIAG_WR;
            end
            S_SC_RD: begin
                cmd.mem_rd = 1'b1;
                cmd.addr   = mk_addr(k_reg, j_reg);
                state_next = S_SC_GO;
            end
            S_SC_GO: begin
                cmd.fpu_start = 1'b1;
                cmd.fpu_op    = FOP_DIV;
                state_next    = S_SC_WAIT;
            end
            S_SC_WAIT: begin
                if (stat.fpu_done) begin
                    cmd.mem_we = 1'b1;
                    cmd.addr   = mk_addr(k_reg, j_reg);
                    cmd.wsel   = WSEL_FPU;
                    j_next     = j_reg + CNT_W'(1);
                    state_next = S_SC_CHK;
                end
            end
            S_DIAG_WR: begin
                cmd.mem_we = 1'b1;
                cmd.addr   = mk_addr(k_reg, k_reg);
                cmd.wsel   = WSEL_ONE;
                i_next     = k_reg + CNT_W'(1);
                state_next = S_ROW_CHK;
            end
            S_ROW_CHK: begin
                state_next = (i_reg < neff_reg) ? S_FAC_RD : S_K_NEXT;
            end
            S_FAC_RD: begin
                cmd.mem_rd = 1'b1;
                cmd.addr   = mk_addr(i_reg, k_reg);
                state_next = S_FAC_LD;
            end
            S_FAC_LD: begin
                cmd.ld_fac = 1'b1;
                j_next     = k_reg + CNT_W'(1);
                state_next = S_EL_CHK;
            end
            S_EL_CHK: begin
                state_next = (j_reg < neff_reg) ? S_B_RD : S_ZERO_WR;
            end
            S_B_RD: begin
                cmd.mem_rd = 1'b1;
                cmd.addr   = mk_addr(k_reg, j_reg);
                state_next = S_B_LD;
            end
            S_B_LD: begin
                cmd.ld_opb = 1'b1;
                cmd.mem_rd = 1'b1;
                cmd.addr   = mk_addr(i_reg, j_reg);
                state_next = S_EL_GO;
            end
            S_EL_GO: begin
                cmd.fpu_start = 1'b1;
                cmd.fpu_op    = FOP_MSUB;
                state_next    = S_EL_WAIT;
            end
            S_EL_WAIT: begin
                cmd.fpu_op = FOP_MSUB;
                if (stat.fpu_done) begin
                    cmd.mem_we = 1'b1;
                    cmd.addr   = mk_addr(i_reg, j_reg);
                    cmd.wsel   = WSEL_FPU;
                    j_next     = j_reg + CNT_W'(1);
                    state_next = S_EL_CHK;
                end
            end
            S_ZERO_WR: begin
                cmd.mem_we = 1'b1;
                cmd.addr   = mk_addr(i_reg, k_reg);
                cmd.wsel   = WSEL_ZERO;
                i_next     = i_reg + CNT_W'(1);
                state_next = S_ROW_CHK;
            end
            S_K_NEXT: begin
                k_next     = k_reg + CNT_W'(1);
                state_next = ((k_reg + CNT_W'(1)) < neff_reg) ? S_PIV_RD : S_RESP;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/gaussian_elimination_engine_core.sv
// ----------------------------------------------------------------------------
// gaussian_elimination_engine_core
// Single-precision Gaussian elimination without pivoting on a 64x64 store.
//
// Input channel s_*: operation 0 writes s_value at (s_row, s_col), 1 runs an
// elimination over the leading n_used rows and columns, 2 reads an element,
// 3 does nothing. Every item gives exactly one transfer on m_*: m_read_value
// (element for a read, zero otherwise) and m_done_res = 1.
// Configuration cfg_*: one write sets n_used (values above 64 act as 64).
// A write or read item passes through its store access state and then the
// response state, which loads the output register and sets m_valid; the
// next item is accepted only after that load. Each update element of an
// elimination needs two reads from the single-port store and the shared FPU
// (rounded multiply then subtract); each pivot-row element uses its divide.
// Reset (aresetn low, synchronous) returns to idle with n_used = 64 and no
// pending result; the store contents stay undefined until written.
// While m_ready is low the finished result is held and one more item may be
// accepted; its result waits until the held one transfers.
// ----------------------------------------------------------------------------
module gaussian_elimination_engine_core
    import gee_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_operation,
    input  logic [IDX_W-1:0]  s_row,
    input  logic [IDX_W-1:0]  s_col,
    input  logic [DATA_W-1:0] s_value,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [NCFG_W-1:0] cfg_data,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_read_value,
    output logic              m_done_res
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    gee_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .stat        (stat)
    );

    gee_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_row        (s_row),
        .s_col        (s_col),
        .s_value      (s_value),
        .m_read_value (m_read_value),
        .m_done_res   (m_done_res)
    );

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of gaussian_elimination_engine_core. Element writes, reads and
// eliminations are sent over the s_* channel with random gaps. A bit-exact
// single-precision model of the store and the elimination predicts every
// m_* transfer, and each one is compared in order. The matrix size register
// is changed between phases: 0, 1, 2, small random sizes, 64 and 127.
// ----------------------------------------------------------------------------
module tb_top;
    import gee_pkg::*;

    localparam int WDOG_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int ITEM_TARGET = 1050;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [1:0]        s_operation;
    logic [IDX_W-1:0]  s_row;
    logic [IDX_W-1:0]  s_col;
    logic [DATA_W-1:0] s_value;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [NCFG_W-1:0] cfg_data;
    logic              m_valid;
    logic              m_ready;
    logic [DATA_W-1:0] m_read_value;
    logic              m_done_res;

    logic [31:0]       mat_q [0:DIM*DIM-1];
    bit                written_q [0:DIM*DIM-1];
    logic [NCFG_W-1:0] size_q;
    logic [31:0]       expected_reads [$];
    int                fail_cnt;
    int                sent_cnt;
    bit                hold_req;
    bit                no_gaps;
    int                idle_cnt;

    gaussian_elimination_engine_core u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_row        (s_row),
        .s_col        (s_col),
        .s_value      (s_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_done_res   (m_done_res)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic bit is_nan(logic [31:0] x);
        return x[30:23] == 8'hFF && x[22:0] != 0;
    endfunction

    function automatic bit is_inf(logic [31:0] x);
        return x[30:0] == 31'h7F80_0000;
    endfunction

    function automatic void fp_unpack(logic [31:0] x, output logic [127:0] m, output int e);
        if (x[30:23] == 0) begin
            m = 128'(x[22:0]);
            e = -149;
        end else begin
            m = 128'({1'b1, x[22:0]});
            e = int'(x[30:23]) - 150;
        end
    endfunction

    // value = m * 2^e, rounded to nearest even; st flags nonzero bits below m
    function automatic logic [31:0] fp_round(logic s, int e, logic [127:0] m, logic st);
        int p;
        int be;
        int sh;
        logic [127:0] q;
        logic g;
        logic r;
        p = 127;
        while (!m[p]) p--;
        be = p + e + 127;
        sh = p - 23;
        if (be < 1) sh = sh + (1 - be);
        if (sh >= 129) begin
            q = 0;
            g = 1'b0;
            r = 1'b1;
        end else if (sh > 0) begin
            q = m >> sh;
            g = m[sh-1];
            r = st | ((m & ((128'b1 << (sh - 1)) - 1)) != 0);
        end else begin
            q = m << (-sh);
            g = 1'b0;
            r = 1'b0;
        end
        if (g && (r || q[0])) q = q + 1;
        if (be < 1) return {s, q[30:0]};
        if (q[24]) begin
            q = q >> 1;
            be++;
        end
        if (be >= 255) return {s, 8'hFF, 23'h0};
        return {s, be[7:0], q[22:0]};
    endfunction

    function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
        logic [31:0] t;
        logic [127:0] ma;
        logic [127:0] mb;
        logic [127:0] big;
        logic [127:0] sml;
        logic [127:0] sum;
        int ea;
        int eb;
        int d;
        if (is_nan(a)) return a | 32'h0040_0000;
        if (is_nan(b)) return b | 32'h0040_0000;
        if (is_inf(a) && is_inf(b) && a[31] != b[31]) return 32'hFFC0_0000;
        if (is_inf(a)) return a;
        if (is_inf(b)) return b;
        if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'h0};
        if (b[30:0] == 0) return a;
        if (a[30:0] == 0) return b;
        if (a[30:0] < b[30:0]) begin
            t = a;
            a = b;
            b = t;
        end
        fp_unpack(a, ma, ea);
        fp_unpack(b, mb, eb);
        d = ea - eb;
        big = ma << 64;
        sml = (d <= 64) ? (mb << (64 - d)) : 128'd1;
        sum = (a[31] == b[31]) ? big + sml : big - sml;
        if (sum == 0) return 32'h0;
        return fp_round(a[31], ea - 64, sum, 1'b0);
    endfunction

    function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
        logic [127:0] ma;
        logic [127:0] mb;
        int ea;
        int eb;
        logic s;
        s = a[31] ^ b[31];
        if (is_nan(a)) return a | 32'h0040_0000;
        if (is_nan(b)) return b | 32'h0040_0000;
        if ((is_inf(a) && b[30:0] == 0) || (is_inf(b) && a[30:0] == 0)) return 32'hFFC0_0000;
        if (is_inf(a) || is_inf(b)) return {s, 31'h7F80_0000};
        if (a[30:0] == 0 || b[30:0] == 0) return {s, 31'h0};
        fp_unpack(a, ma, ea);
        fp_unpack(b, mb, eb);
        return fp_round(s, ea + eb, ma * mb, 1'b0);
    endfunction

    function automatic logic [31:0] fp_div(logic [31:0] x, logic [31:0] dv);
        logic [127:0] mx;
        logic [127:0] md;
        logic [127:0] q;
        int ex;
        int ed;
        logic s;
        s = x[31] ^ dv[31];
        if (dv[30:0] == 0) begin
            if (is_nan(x)) return x;
            if (x[30:0] == 0) return 32'h7FC0_0000;
            return {s, 31'h7F80_0000};
        end
        if (is_nan(x)) return x | 32'h0040_0000;
        if (is_nan(dv)) return dv | 32'h0040_0000;
        if (is_inf(x) && is_inf(dv)) return 32'hFFC0_0000;
        if (is_inf(x)) return {s, 31'h7F80_0000};
        if (is_inf(dv) || x[30:0] == 0) return {s, 31'h0};
        fp_unpack(x, mx, ex);
        fp_unpack(dv, md, ed);
        q = (mx << 100) / md;
        return fp_round(s, ex - ed - 100, q, ((mx << 100) % md) != 0);
    endfunction

    function automatic logic [31:0] fp_msub(logic [31:0] a, logic [31:0] f, logic [31:0] b);
        logic [31:0] prod;
        prod = fp_mul(f, b);
        if (is_nan(a)) return a | 32'h0040_0000;
        if (is_nan(prod)) return prod | 32'h0040_0000;
        return fp_add(a, prod ^ 32'h8000_0000);
    endfunction

    function automatic void eliminate_store();
        int n;
        logic [31:0] piv;
        logic [31:0] f;
        n = (size_q > DIM) ? DIM : int'(size_q);
        for (int k = 0; k < n; k++) begin
            piv = mat_q[k*DIM+k];
            for (int j = k + 1; j < n; j++)
                mat_q[k*DIM+j] = fp_div(mat_q[k*DIM+j], piv);
            mat_q[k*DIM+k] = FP_ONE;
            for (int i = k + 1; i < n; i++) begin
                f = mat_q[i*DIM+k];
                for (int j = k + 1; j < n; j++)
                    mat_q[i*DIM+j] = fp_msub(mat_q[i*DIM+j], f, mat_q[k*DIM+j]);
                mat_q[i*DIM+k] = FP_ZERO;
            end
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(op_t op, int r, int c, logic [31:0] v);
        int gap;
        int idx;
        s_valid     <= 1'b1;
        s_operation <= op;
        s_row       <= IDX_W'(r);
        s_col       <= IDX_W'(c);
        s_value     <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        idx = r * DIM + c;
        case (op)
            OP_WRITE: begin
                mat_q[idx] = v;
                written_q[idx] = 1'b1;
                expected_reads.push_back(FP_ZERO);
            end
            OP_START: begin
                eliminate_store();
                expected_reads.push_back(FP_ZERO);
            end
            OP_READ: expected_reads.push_back(mat_q[idx]);
            default: expected_reads.push_back(FP_ZERO);
        endcase
        sent_cnt++;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_reads.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic set_size(logic [NCFG_W-1:0] n);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        size_q = n;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] tame_value(bit diag);
        logic [7:0] ex;
        ex = diag ? 8'($urandom_range(131, 134)) : 8'($urandom_range(118, 128));
        return {1'($urandom), ex, 23'($urandom)};
    endfunction

    task automatic read_region(int n);
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                send_item(OP_READ, i, j, 32'($urandom));
    endtask

    task automatic test_extremes();
        set_size(7'd64);
        send_item(OP_WRITE, 0, 0, 32'h0000_0000);
        send_item(OP_WRITE, 63, 63, 32'hFFFF_FFFF);
        send_item(OP_WRITE, 0, 63, 32'h8000_0001);
        send_item(OP_WRITE, 63, 0, 32'h7F80_0000);
        send_item(OP_READ, 63, 63, 32'hFFFF_FFFF);
        send_item(OP_READ, 0, 0, 32'h0);
        send_item(OP_READ, 0, 63, 32'h0);
        send_item(OP_READ, 63, 0, 32'h0);
        send_item(OP_NONE, 63, 63, 32'hFFFF_FFFF);
    endtask

    task automatic test_zero_pivot();
        set_size(7'd2);
        send_item(OP_WRITE, 0, 0, 32'h0000_0000);
        send_item(OP_WRITE, 0, 1, 32'h4040_0000);
        send_item(OP_WRITE, 1, 0, 32'h4000_0000);
        send_item(OP_WRITE, 1, 1, 32'h40A0_0000);
        send_item(OP_START, 0, 0, 32'h0);
        read_region(2);
        send_item(OP_WRITE, 0, 1, 32'h0000_0000);
        send_item(OP_START, 0, 0, 32'h0);
        send_item(OP_READ, 0, 1, 32'h0);
    endtask

    task automatic test_sizes_zero_and_above();
        set_size(7'd0);
        send_item(OP_START, 5, 5, 32'h0);
        send_item(OP_READ, 0, 0, 32'h0);
        set_size(7'd127);
        send_item(OP_READ, 63, 63, 32'h0);
        set_size(7'd1);
        send_item(OP_START, 0, 0, 32'h0);
        send_item(OP_READ, 0, 0, 32'h0);
    endtask

    task automatic test_output_hold();
        hold_req = 1'b1;
        for (int i = 0; i < 16; i++) begin
            if (i % 2 == 0)
                send_item(OP_WRITE, i, 40, 32'($urandom));
            else
                send_item(OP_READ, i - 1, 40, 32'h0);
        end
        wait_drain();
    endtask

    task automatic test_random();
        int n;
        int r;
        int c;
        while (sent_cnt < ITEM_TARGET) begin
            no_gaps = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) < 7) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
                set_size(7'(n));
                for (int i = 0; i < n; i++)
                    for (int j = 0; j < n; j++)
                        send_item(OP_WRITE, i, j, tame_value(i == j));
                send_item(OP_START, 0, 0, 32'($urandom));
                read_region(n);
            end else begin
                for (int k = 0; k < 20; k++) begin
                    r = $urandom_range(0, 63);
                    c = $urandom_range(0, 63);
                    case ($urandom_range(0, 5))
                        0, 1, 2: send_item(OP_WRITE, r, c, 32'($urandom));
                        3: send_item(OP_NONE, r, c, 32'($urandom));
                        default: begin
                            if (!written_q[r*DIM+c]) send_item(OP_WRITE, r, c, 32'($urandom));
                            send_item(OP_READ, r, c, 32'($urandom));
                        end
                    endcase
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_operation = OP_NONE;
        s_row       = '0;
        s_col       = '0;
        s_value     = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        fail_cnt    = 0;
        sent_cnt    = 0;
        hold_req    = 1'b0;
        no_gaps     = 1'b0;
        size_q      = N_RESET;
        for (int i = 0; i < DIM * DIM; i++) begin
            written_q[i] = 1'b0;
            mat_q[i] = FP_ZERO;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_zero_pivot();
        test_sizes_zero_and_above();
        test_output_hold();
        test_random();
        set_size(7'd64);
        wait_drain();
        repeat (50) @(posedge aclk);
        if (fail_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (!no_gaps && $urandom_range(0, 99) >= 60) begin
                m_ready <= 1'b0;
                repeat (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 3))
                    @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_reads.size() == 0) begin
                $display("%0t: unexpected transfer, read_value %h", $realtime, m_read_value);
                fail_cnt++;
            end else begin
                if (m_read_value !== expected_reads[0]) begin
                    $display("%0t: read_value expected %h actual %h",
                             $realtime, expected_reads[0], m_read_value);
                    fail_cnt++;
                end
                if (m_done_res !== 1'b1) begin
                    $display("%0t: done_res expected 1 actual %b", $realtime, m_done_res);
                    fail_cnt++;
                end
                void'(expected_reads.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cnt <= 0;
        else if (idle_cnt >= WDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else
            idle_cnt <= idle_cnt + 1;
    end

    initial idle_cnt = 0;

endmodule
